FILE: rtl/bpmt_pkg.sv
// ----------------------------------------------------------------------------
// Breakpoint match table package
// Shared widths, operation and status codes, and default table size.
// ----------------------------------------------------------------------------
package bpmt_pkg;

	localparam int TABLE_ENTRIES_DEF = 16;

	localparam int OP_W     = 2;
	localparam int ID_W     = 32;
	localparam int TYPE_W   = 2;
	localparam int ADDR_W   = 64;
	localparam int SIZE_W   = 4;
	localparam int STATUS_W = 2;

	localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
	localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

	localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

	localparam logic [TYPE_W-1:0] HW_TYPE_EXEC = 2'd0;

endpackage

FILE: rtl/bpmt_if.sv
// ----------------------------------------------------------------------------
// Breakpoint match table channels
// Valid/ready channels for requests into the table and results out of it.
// ----------------------------------------------------------------------------
interface bpmt_req_if;
	import bpmt_pkg::*;

	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   op;
	logic [ID_W-1:0]   bp_id;
	logic              is_hard;
	logic [TYPE_W-1:0] hw_type;
	logic [ADDR_W-1:0] address;
	logic [SIZE_W-1:0] access_size;

	modport source (output valid, op, bp_id, is_hard, hw_type, address, access_size,
		input ready);
	modport sink (input valid, op, bp_id, is_hard, hw_type, address, access_size,
		output ready);
endinterface

interface bpmt_rsp_if;
	import bpmt_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic                match_found;
	logic [ID_W-1:0]     match_id;

	modport source (output valid, status, match_found, match_id, input ready);
	modport sink (input valid, status, match_found, match_id, output ready);
endinterface

FILE: rtl/bpmt_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, with registered read data.
// ----------------------------------------------------------------------------
module bpmt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/breakpoint_match_table_core.sv
// ----------------------------------------------------------------------------
// Breakpoint match table core
// Table of breakpoints with add/update, delete and newest-match lookup.
// ----------------------------------------------------------------------------
// A request on req carries an operation and the breakpoint attributes; each
// request gives exactly one result on rsp (status, match flag, matching id).
// The table entries live in a RAM that a small sequencer walks one entry per
// cycle; per-entry valid flags are held in flip-flops. req.ready is high only
// while the sequencer is idle, so one request is worked on at a time.
// Every request first sweeps the table. A lookup, a missed delete, an add
// to a full table or an unused operation then has its result loaded in the
// finish state; an in-place update first writes the entry in the write state.
// Adding a new id and deleting an id take a second sweep that rewrites the
// age ranks of the valid entries; a new id is then written in the write state.
// The sequencer can accept the next request in the cycle after the result
// register is loaded, and a stalled receiver only holds the sequencer back
// once a further result is ready to be written.
// Reset empties the table by clearing all valid flags and drops any pending
// result; the RAM contents need no clearing.
// ----------------------------------------------------------------------------
module breakpoint_match_table_core #(
	parameter int TABLE_ENTRIES = bpmt_pkg::TABLE_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	bpmt_req_if.sink    req,
	bpmt_rsp_if.source  rsp
);
	import bpmt_pkg::*;

	localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam logic [IW:0] LAST_CNT = (IW+1)'(TABLE_ENTRIES);

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic              hard;
		logic [TYPE_W-1:0] hw_type;
		logic [ADDR_W-1:0] address;
		logic [SIZE_W-1:0] size;
		logic [IW-1:0]     rank;
	} entry_t;

	localparam int EW = $bits(entry_t);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_ADJUST,
		ST_WRITE,
		ST_FINISH
	} state_t;

	state_t state_q;

	// Latched request.
	logic [OP_W-1:0]   op_q;
	logic [ID_W-1:0]   id_q;
	logic              hard_q;
	logic [TYPE_W-1:0] type_q;
	logic [ADDR_W-1:0] addr_q;
	logic [SIZE_W-1:0] size_q;

	logic [TABLE_ENTRIES-1:0] valid_q;

	// Sweep pointer and the read that is in flight.
	logic [IW:0]   rd_cnt_q;
	logic          d_vld_q;
	logic [IW-1:0] d_idx_q;

	// Sweep findings.
	logic          hit_q;
	logic [IW-1:0] hit_idx_q;
	logic [IW-1:0] hit_rank_q;
	logic          free_q;
	logic [IW-1:0] free_idx_q;
	logic          found_q;
	logic [IW-1:0] best_q;
	logic [ID_W-1:0] mid_q;
	logic [STATUS_W-1:0] status_q;

	logic [IW-1:0] tgt_idx_q;
	logic [IW-1:0] tgt_rank_q;

	logic                rsp_valid_q;
	logic [STATUS_W-1:0] rsp_status_q;
	logic                rsp_found_q;
	logic [ID_W-1:0]     rsp_id_q;

	// RAM port signals.
	logic          ram_we;
	logic [IW-1:0] ram_waddr;
	entry_t        ram_wdata;
	logic [IW-1:0] ram_raddr;
	logic [EW-1:0] ram_rdata;
	entry_t        rd_entry;

	logic sweeping;
	logic sweep_done;
	logic slot_v;
	logic id_hit;
	logic slot_match;
	logic [IW-1:0] adj_rank;

	assign rd_entry   = entry_t'(ram_rdata);
	assign sweeping   = (state_q == ST_SCAN) || (state_q == ST_ADJUST);
	assign sweep_done = (rd_cnt_q == LAST_CNT) && !d_vld_q;
	assign slot_v     = valid_q[d_idx_q];
	assign id_hit     = slot_v && (rd_entry.id == id_q);

	always_comb begin
		slot_match = slot_v && (rd_entry.hard == hard_q) && (rd_entry.address == addr_q);
		if (hard_q) begin
			if (rd_entry.hw_type != type_q) begin
				slot_match = 1'b0;
			end else if ((type_q != HW_TYPE_EXEC) && (rd_entry.size != size_q)) begin
				slot_match = 1'b0;
			end
		end
	end

	// Adding a new entry ages every valid entry; a delete closes the gap
	// left above the removed rank.
	always_comb begin
		adj_rank = rd_entry.rank;
		if (op_q == OP_ADD) begin
			adj_rank = rd_entry.rank + IW'(1);
		end else if (rd_entry.rank > hit_rank_q) begin
			adj_rank = rd_entry.rank - IW'(1);
		end
	end

	always_comb begin
		ram_raddr = rd_cnt_q[IW-1:0];
		ram_we    = 1'b0;
		ram_waddr = d_idx_q;
		ram_wdata = rd_entry;
		case (state_q)
			ST_ADJUST: begin
				ram_we         = d_vld_q && slot_v;
				ram_wdata.rank = adj_rank;
			end
			ST_WRITE: begin
				ram_we    = 1'b1;
				ram_waddr = tgt_idx_q;
				ram_wdata = '{id: id_q, hard: hard_q, hw_type: type_q, address: addr_q,
					size: size_q, rank: tgt_rank_q};
			end
			default: begin
			end
		endcase
	end

	bpmt_ram #(
		.WIDTH (EW),
		.DEPTH (TABLE_ENTRIES)
	) u_entry_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			op_q         <= '0;
			id_q         <= '0;
			hard_q       <= 1'b0;
			type_q       <= '0;
			addr_q       <= '0;
			size_q       <= '0;
			valid_q      <= '0;
			rd_cnt_q     <= '0;
			d_vld_q      <= 1'b0;
			d_idx_q      <= '0;
			hit_q        <= 1'b0;
			hit_idx_q    <= '0;
			hit_rank_q   <= '0;
			free_q       <= 1'b0;
			free_idx_q   <= '0;
			found_q      <= 1'b0;
			best_q       <= '0;
			mid_q        <= '0;
			status_q     <= STATUS_OK;
			tgt_idx_q    <= '0;
			tgt_rank_q   <= '0;
			rsp_valid_q  <= 1'b0;
			rsp_status_q <= STATUS_OK;
			rsp_found_q  <= 1'b0;
			rsp_id_q     <= '0;
		end else begin
			// The finish state loads the next result itself when the register drains.
			if (rsp_valid_q && rsp.ready && (state_q != ST_FINISH)) begin
				rsp_valid_q <= 1'b0;
			end

			// Issue one read per cycle while sweeping; data returns in the following cycle.
			if (sweeping && (rd_cnt_q != LAST_CNT)) begin
				rd_cnt_q <= rd_cnt_q + (IW+1)'(1);
				d_vld_q  <= 1'b1;
				d_idx_q  <= rd_cnt_q[IW-1:0];
			end else begin
				d_vld_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						op_q     <= req.op;
						id_q     <= req.bp_id;
						hard_q   <= req.is_hard;
						type_q   <= req.hw_type;
						addr_q   <= req.address;
						size_q   <= req.access_size;
						rd_cnt_q <= '0;
						hit_q    <= 1'b0;
						free_q   <= 1'b0;
						found_q  <= 1'b0;
						mid_q    <= '0;
						status_q <= STATUS_OK;
						state_q  <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (d_vld_q) begin
						if (id_hit && !hit_q) begin
							hit_q      <= 1'b1;
							hit_idx_q  <= d_idx_q;
							hit_rank_q <= rd_entry.rank;
						end
						if (!slot_v && !free_q) begin
							free_q     <= 1'b1;
							free_idx_q <= d_idx_q;
						end
						if ((op_q == OP_LOOKUP) && slot_match &&
							(!found_q || (rd_entry.rank < best_q))) begin
							found_q <= 1'b1;
							best_q  <= rd_entry.rank;
							mid_q   <= rd_entry.id;
						end
					end
					if (sweep_done) begin
						rd_cnt_q <= '0;
						case (op_q)
							OP_ADD: begin
								if (hit_q) begin
									tgt_idx_q  <= hit_idx_q;
									tgt_rank_q <= hit_rank_q;
									state_q    <= ST_WRITE;
								end else if (free_q) begin
									tgt_idx_q  <= free_idx_q;
									tgt_rank_q <= '0;
									state_q    <= ST_ADJUST;
								end else begin
									status_q <= STATUS_FULL;
									state_q  <= ST_FINISH;
								end
							end
							OP_DELETE: begin
								if (hit_q) begin
									valid_q[hit_idx_q] <= 1'b0;
									state_q            <= ST_ADJUST;
								end else begin
									status_q <= STATUS_NOT_FOUND;
									state_q  <= ST_FINISH;
								end
							end
							default: begin
								state_q <= ST_FINISH;
							end
						endcase
					end
				end
				ST_ADJUST: begin
					if (sweep_done) begin
						state_q <= (op_q == OP_ADD) ? ST_WRITE : ST_FINISH;
					end
				end
				ST_WRITE: begin
					valid_q[tgt_idx_q] <= 1'b1;
					state_q            <= ST_FINISH;
				end
				ST_FINISH: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q  <= 1'b1;
						rsp_status_q <= status_q;
						rsp_found_q  <= found_q;
						rsp_id_q     <= mid_q;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign req.ready       = (state_q == ST_IDLE);
	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.match_found = rsp_found_q;
	assign rsp.match_id    = rsp_id_q;

endmodule
